// ----- rtl/rtp_pkg.sv -----
// Shared types and constants for the rectangular to polar converter.
package rtp_pkg;

  // Guard bits carried below the output fraction in the CORDIC datapath.
  localparam int GUARD_BITS = 12;

  // Fraction bits of the angle accumulator, in degrees.
  localparam int ANGLE_FRAC = 24;

  // Width of the angle accumulator; holds +-180 degrees plus the arctangent sum.
  localparam int ZW = 34;

  // 180 degrees in the accumulator format.
  localparam logic signed [ZW-1:0] Z180 = 34'sd3019898880;

  // Angle of an item that lies on an axis.
  typedef enum logic [1:0] {
    ANG_ZERO,
    ANG_POS90,
    ANG_NEG90,
    ANG_180
  } axis_ang_t;

  // Control that travels beside the datapath through every stage.
  typedef struct packed {
    logic      axis;
    axis_ang_t code;
  } side_t;

  // round(atan(2^-i) * 180/pi * 2^24) for each micro-rotation.
  localparam logic [29:0] ATAN_DEG_Q24 [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,
    30'd57,        30'd29,        30'd14,        30'd7,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // Reciprocal CORDIC gain in Q32 for 8 to 17 micro-rotations; more share the last.
  localparam logic [31:0] GAIN_Q32 [10] = '{
    32'd2608158028, 32'd2608138129, 32'd2608133154, 32'd2608131911,
    32'd2608131600, 32'd2608131522, 32'd2608131503, 32'd2608131498,
    32'd2608131497, 32'd2608131496
  };

endpackage

// ----- rtl/rtp_cell.sv -----
// One CORDIC vectoring micro-rotation, registered, with a fixed shift.
module rtp_cell #(
  parameter int W     = 39,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [W-1:0]           in_x,
  input  logic signed [W-1:0]           in_y,
  input  logic signed [rtp_pkg::ZW-1:0] in_z,
  input  rtp_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic signed [W-1:0]           out_x,
  output logic signed [W-1:0]           out_y,
  output logic signed [rtp_pkg::ZW-1:0] out_z,
  output rtp_pkg::side_t                out_side
);
  import rtp_pkg::*;

  logic signed [W-1:0]  dx;
  logic signed [W-1:0]  dy;
  logic signed [ZW-1:0] at;
  logic signed [W-1:0]  x_next;
  logic signed [W-1:0]  y_next;
  logic signed [ZW-1:0] z_next;

  // Rotate toward the x axis; items on an axis pass through untouched.
  always_comb begin
    dx = in_y >>> SHIFT;
    dy = in_x >>> SHIFT;
    at = $signed(ZW'(ATAN_DEG_Q24[SHIFT]));
    if (in_side.axis) begin
      x_next = in_x;
      y_next = in_y;
      z_next = in_z;
    end else if (!in_y[W-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      z_next = in_z + at;
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      z_next = in_z - at;
    end
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/rtp_scale.sv -----
// Gain correction of the magnitude and rounding of both results, two stages.
module rtp_scale #(
  parameter int W             = 39,
  parameter int FRAC_BITS     = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [W-1:0]           in_x,
  input  logic signed [rtp_pkg::ZW-1:0] in_z,
  input  rtp_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [23:0]                   magnitude,
  output logic signed [16:0]            angle_deg
);
  import rtp_pkg::*;

  localparam int GAIN_IDX = (CORDIC_STAGES > 17) ? 9 : CORDIC_STAGES - 8;
  localparam int AW = 36;
  localparam int S = ANGLE_FRAC - FRAC_BITS;
  localparam logic signed [AW-1:0] FULL = AW'(180 << FRAC_BITS);
  localparam logic signed [AW-1:0] QUARTER = AW'(90 << FRAC_BITS);
  localparam logic signed [AW-1:0] RND = AW'(1 << (S - 1));
  localparam logic [31:0] GAIN = GAIN_Q32[GAIN_IDX];
  localparam logic [63:0] MAG_MAX = 64'hFFFFFF;

  logic [63:0]          ux;
  logic [63:0]          prod_lo;
  logic [63:0]          prod_hi;
  logic signed [AW-1:0] ang_raw;
  logic signed [AW-1:0] ang_sel;

  logic                 v1;
  logic                 axis1;
  logic [63:0]          p_hi;
  logic [31:0]          p_lo_top;
  logic [16:0]          ang1;

  logic                 v2;
  logic                 axis2;
  logic [63:0]          sum;
  logic [16:0]          ang2;

  logic [63:0]          rnd_mag;
  logic [63:0]          mag_sel;

  // Partial products of the gain multiply and the rounded, clamped angle.
  always_comb begin
    ux      = 64'(in_x[W-2:0]);
    prod_lo = 64'(ux[31:0]) * 64'(GAIN);
    prod_hi = 64'(ux[63:32]) * 64'(GAIN);
    ang_raw = (AW'(in_z) + RND) >>> S;
    if (in_side.axis) begin
      case (in_side.code)
        ANG_POS90: ang_sel = QUARTER;
        ANG_NEG90: ang_sel = -QUARTER;
        ANG_180:   ang_sel = FULL;
        default:   ang_sel = '0;
      endcase
    end else if (ang_raw > FULL || ang_raw <= -FULL) begin
      ang_sel = FULL;
    end else begin
      ang_sel = ang_raw;
    end
  end

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Product stage, then sum stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      axis1 <= in_side.axis;
      ang1  <= ang_sel[16:0];
      if (in_side.axis) begin
        p_hi     <= ux << FRAC_BITS;
        p_lo_top <= '0;
      end else begin
        p_hi     <= prod_hi;
        p_lo_top <= prod_lo[63:32];
      end
      axis2 <= axis1;
      ang2  <= ang1;
      sum   <= p_hi + 64'(p_lo_top);
    end
  end

  // Drop the guard bits with round half up, except for items on an axis, then saturate to 24 bits.
  always_comb begin
    rnd_mag = (sum + (64'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
    mag_sel = axis2 ? sum : rnd_mag;
    magnitude = (mag_sel > MAG_MAX) ? MAG_MAX[23:0] : mag_sel[23:0];
  end

  assign angle_deg = $signed(ang2);
  assign out_valid = v2;

endmodule

// ----- rtl/rect_to_polar_degrees.sv -----
// Top level of the rectangular to polar converter: input stage, CORDIC row, gain correction, output buffer.
//
// Converts a signed point (x, y) into its magnitude and its angle atan2(y, x)
// in degrees, range (-180, 180], both rounded to FRAC_BITS fraction bits.
// Input channel s_axis: x_coord in tdata[15:0], y_coord in tdata[31:16].
// Output channel m_axis: magnitude in tdata[23:0], angle_deg in tdata[40:24].
// Points on an axis are answered exactly; all others go through a row of
// CORDIC_STAGES vectoring cells, one micro-rotation per cell, after a
// 180 degree pre-rotation for negative x.
// Throughput: one item per cycle while no stall holds the pipeline, set by the fully pipelined cell row.
// From acceptance to tvalid an item passes the input stage, loaded at the accepting edge,
// the register of each cell, the two gain and rounding stages and the output register.
// The pipeline moves as a whole; an output register plus a one-item skid
// buffer keep s_axis_tready registered. When the receiver stalls, the skid
// buffer fills, tready drops and every stage holds its item; nothing is lost.
// Reset clears all valid flags; no item is in flight afterwards.
module rect_to_polar_degrees #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRAC_BITS     = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // x_coord [15:0], y_coord [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // magnitude [23:0], angle_deg [40:24]
);
  import rtp_pkg::*;

  localparam int XW = (COORD_WIDTH > 16) ? 17 : COORD_WIDTH;
  localparam int SC = FRAC_BITS + GUARD_BITS;
  localparam int W  = XW + 3 + SC;
  localparam int N  = CORDIC_STAGES;

  logic                 adv;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW:0]   x_e;
  logic signed [XW:0]   y_e;
  logic signed [XW:0]   abs_x;
  logic signed [XW:0]   abs_y;
  logic signed [XW:0]   y_rot;
  logic signed [W-1:0]  x0_next;
  logic signed [W-1:0]  y0_next;
  logic signed [ZW-1:0] z0_next;
  side_t                side0_next;

  logic                 cv [N+1];
  logic signed [W-1:0]  cx [N+1];
  logic signed [W-1:0]  cy [N+1];
  logic signed [ZW-1:0] cz [N+1];
  side_t                cs [N+1];

  logic                 p_valid;
  logic [23:0]          p_mag;
  logic signed [16:0]   p_ang;

  logic                 skid_valid;
  logic [23:0]          skid_mag;
  logic [16:0]          skid_ang;
  logic [23:0]          out_mag;
  logic [16:0]          out_ang;

  // Take the low COORD_WIDTH bits of each field as a signed value; above 16 bits, the 16-bit field is zero-extended.
  if (COORD_WIDTH > 16) begin : g_wide
    assign xs = $signed({1'b0, s_axis_tdata[15:0]});
    assign ys = $signed({1'b0, s_axis_tdata[31:16]});
  end else begin : g_narrow
    assign xs = $signed(s_axis_tdata[COORD_WIDTH-1:0]);
    assign ys = $signed(s_axis_tdata[16 +: COORD_WIDTH]);
  end

  // Axis detection, absolute values and the pre-rotation for negative x.
  always_comb begin
    x_e   = (XW + 1)'(xs);
    y_e   = (XW + 1)'(ys);
    abs_x = x_e[XW] ? -x_e : x_e;
    abs_y = y_e[XW] ? -y_e : y_e;
    y_rot = x_e[XW] ? -y_e : y_e;
    z0_next = '0;
    y0_next = '0;
    if (ys == '0) begin
      side0_next.axis = 1'b1;
      side0_next.code = x_e[XW] ? ANG_180 : ANG_ZERO;
      x0_next = W'(abs_x);
    end else if (xs == '0) begin
      side0_next.axis = 1'b1;
      side0_next.code = y_e[XW] ? ANG_NEG90 : ANG_POS90;
      x0_next = W'(abs_y);
    end else begin
      side0_next.axis = 1'b0;
      side0_next.code = ANG_ZERO;
      x0_next = W'(abs_x) <<< SC;
      y0_next = W'(y_rot) <<< SC;
      if (x_e[XW]) begin
        z0_next = y_e[XW] ? -Z180 : Z180;
      end
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= x0_next;
      cy[0] <= y0_next;
      cz[0] <= z0_next;
      cs[0] <= side0_next;
    end
  end

  // Row of CORDIC cells, shift i in cell i.
  for (genvar i = 0; i < N; i++) begin : g_cell
    rtp_cell #(
      .W     (W),
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_side   (cs[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_side  (cs[i+1])
    );
  end

  // Gain correction and rounding.
  rtp_scale #(
    .W             (W),
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cv[N]),
    .in_x      (cx[N]),
    .in_z      (cz[N]),
    .in_side   (cs[N]),
    .out_valid (p_valid),
    .magnitude (p_mag),
    .angle_deg (p_ang)
  );

  // The pipeline advances whenever the skid buffer has room.
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  // Output register and skid buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= p_valid;
      end
    end else if (p_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid buffer payload.
  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        out_mag <= skid_mag;
        out_ang <= skid_ang;
      end else begin
        out_mag <= p_mag;
        out_ang <= p_ang;
      end
    end else if (adv) begin
      skid_mag <= p_mag;
      skid_ang <= p_ang;
    end
  end

  assign m_axis_tdata = {7'b0, out_ang, out_mag};

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the rectangular to polar converter.
module tb;

  localparam int FRAC_BITS     = 8;
  localparam int GUARD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASES        = 4;

  // Degrees in the output format and the CORDIC working scale.
  localparam longint HALF_TURN   = 180 * (1 << FRAC_BITS);
  localparam longint RIGHT_ANGLE = 90 * (1 << FRAC_BITS);
  localparam longint CORDIC_ONE  = longint'(1) << (FRAC_BITS + GUARD_BITS);
  localparam int     ACC_SHIFT   = 24 - FRAC_BITS;

  // Inverse CORDIC gain for sixteen micro-rotations, Q32.
  localparam logic [63:0] INV_GAIN = 64'd2608131497;

  // Arctangent of 2^-i in degrees, Q24.
  localparam longint ATAN_Q24 [CORDIC_STAGES] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  typedef struct packed {
    logic [23:0]        mag;
    logic signed [16:0] ang;
  } polar_t;

  // One directed point; typed rows carry a hand-written answer.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               typed;
    logic [23:0]        mag;
    logic signed [16:0] ang;
  } point_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam point_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Origin, both axes at full scale and at unit distance.
    '{0, 0, 1, 0, 0},
    '{32767, 0, 1, 8388352, 0},
    '{-32768, 0, 1, 8388608, 46080},
    '{0, 32767, 1, 8388352, 23040},
    '{0, -32768, 1, 8388608, -23040},
    '{1, 0, 1, 256, 0},
    '{-1, 0, 1, 256, 46080},
    '{0, 1, 1, 256, 23040},
    '{0, -1, 1, 256, -23040},
    '{-32767, 0, 1, 8388352, 46080},
    // Corners of the input range and the four unit diagonals.
    '{32767, 32767, 0, 0, 0},
    '{-32768, -32768, 0, 0, 0},
    '{-32768, 32767, 0, 0, 0},
    '{32767, -32768, 0, 0, 0},
    '{1, 1, 0, 0, 0},
    '{-1, 1, 0, 0, 0},
    '{-1, -1, 0, 0, 0},
    '{1, -1, 0, 0, 0},
    // Just above and below the negative x axis, where the angle wraps, then three other points.
    '{-32768, 1, 0, 0, 0},
    '{-32768, -1, 0, 0, 0},
    '{-32767, -1, 0, 0, 0},
    '{-1, -32768, 0, 0, 0},
    '{3, -4, 0, 0, 0},
    '{-12345, 6789, 0, 0, 0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;

  polar_t pending_polar [$];
  int     mismatches  = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  rect_to_polar_degrees #(
    .COORD_WIDTH(16),
    .FRAC_BITS(FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Magnitude and angle of one point: exact on the axes, vectoring CORDIC elsewhere.
  function automatic polar_t to_polar(input logic signed [15:0] px,
                                      input logic signed [15:0] py);
    longint      x, y, cx, cy, z, dx, dy, a;
    logic [63:0] ux, v, m;
    polar_t      r;
    x = px;
    y = py;
    if (y == 0) begin
      m = (x < 0 ? -x : x) << FRAC_BITS;
      a = (x < 0) ? HALF_TURN : 0;
    end else if (x == 0) begin
      m = (y < 0 ? -y : y) << FRAC_BITS;
      a = (y > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
    end else begin
      // Left half-plane points are turned by 180 degrees first.
      cx = (x < 0 ? -x : x) * CORDIC_ONE;
      cy = (x < 0 ? -y : y) * CORDIC_ONE;
      z = 0;
      if (x < 0) z = (y > 0 ? 180 : -180) * (longint'(1) << 24);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ATAN_Q24[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ATAN_Q24[i];
        end
      end
      // Gain correction split into high and low words, then round away the guard bits.
      ux = cx;
      v = (ux >> 32) * INV_GAIN + (((ux & 64'hFFFF_FFFF) * INV_GAIN) >> 32);
      m = (v + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      a = (z + (longint'(1) << (ACC_SHIFT - 1))) >>> ACC_SHIFT;
      if (a > HALF_TURN) a = HALF_TURN;
      if (a <= -HALF_TURN) a = HALF_TURN;
    end
    if (m > 64'hFF_FFFF) m = 64'hFF_FFFF;
    r.mag = m[23:0];
    r.ang = a[16:0];
    return r;
  endfunction

  // Offer one point, with a random gap first, and hold it until accepted.
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input bit typed, input polar_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_polar.push_back(typed ? want : to_polar(px, py));
  endtask

  // Random point, biased toward the axes, the wrap at 180 degrees, small radii and edge values.
  task automatic send_random_point();
    logic signed [15:0] px, py;
    int                 pick;
    logic signed [15:0] corners [6];
    corners = '{-32768, -32767, -1, 0, 1, 32767};
    pick = $urandom_range(9);
    px = 16'($urandom);
    py = 16'($urandom);
    case (pick)
      0: begin
        if ($urandom_range(1)) px = 0;
        else py = 0;
      end
      1: begin
        px = 16'(-$signed(17'($urandom_range(32768, 16384))));
        py = $signed(16'($urandom_range(6))) - 16'sd3;
      end
      2: begin
        px = $signed(16'($urandom_range(16))) - 16'sd8;
        py = $signed(16'($urandom_range(16))) - 16'sd8;
      end
      3: begin
        px = corners[$urandom_range(5)];
        if ($urandom_range(1)) py = corners[$urandom_range(5)];
      end
      default: ;
    endcase
    send_point(px, py, 1'b0, '0);
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result(input logic [47:0] data);
    polar_t want;
    polar_t got;
    got.mag = data[23:0];
    got.ang = $signed(data[40:24]);
    if (pending_polar.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: mag=%0d ang=%0d", got.mag, got.ang);
    end else begin
      want = pending_polar.pop_front();
      if (got.mag !== want.mag || got.ang !== want.ang) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected mag=%0d ang=%0d, got mag=%0d ang=%0d",
                   want.mag, want.ang, got.mag, got.ang);
      end
    end
  endtask

  // Receiver: take results and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: directed points, then random points over four phases of sender idling and receiver stalls.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (phase == 0) begin
        for (int i = 0; i < DIRECTED_ROWS; i++)
          send_point(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].typed,
                     '{DIRECTED[i].mag, DIRECTED[i].ang});
      end
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_random_point();
      // The sender holds off until the pipeline has drained.
      s_axis_tvalid <= 1'b0;
      while (pending_polar.size() != 0) @(posedge clk);
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_polar.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rtp_pkg.sv
rtl/rtp_cell.sv
rtl/rtp_scale.sv
rtl/rect_to_polar_degrees.sv
tb/sv/tb.sv
